// File: design/assert_macros.svh
// assertion macros used by the timer design file
// clocked on i_clk; MCT_ASSERT is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define MCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define MCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/mct_pkg.sv
// types, codes and constants of the countdown timer bank
// no dependencies
package mct_pkg;

    localparam int SLOT_W        = 3;
    localparam int COUNT_W       = 15;
    localparam int LOAD_W        = 15;
    localparam int MAX_REPORTS   = 8;
    localparam int REP_CNT_W     = 4;
    localparam int NUM_SLOTS_DEF = 8;
    localparam int IDX_WIDE_W    = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET      = 2'd1,
        KIND_SET_IDLE = 2'd2,
        KIND_STOP     = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RD    = 5'b00100,
        S_UPD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // load plus one, saturating at the largest count
    function automatic logic [COUNT_W-1:0] sat_load(input logic [LOAD_W-1:0] load);
        logic [COUNT_W-1:0] v;
        v = (load == COUNT_MAX) ? COUNT_MAX : load + COUNT_W'(1);
        return v;
    endfunction

endpackage

// File: design/mct_ifs.sv
// valid/ready channel interfaces for commands and expiry reports
// depends on mct_pkg
interface mct_cmd_if import mct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot_index;
    logic [LOAD_W-1:0] load_value;
    logic              notify;

    modport source (output valid, kind, slot_index, load_value, notify, input ready);
    modport sink (input valid, kind, slot_index, load_value, notify, output ready);
endinterface

interface mct_rep_if import mct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] expired_slot;
    logic              last;

    modport source (output valid, expired_slot, last, input ready);
    modport sink (input valid, expired_slot, last, output ready);
endinterface

// File: design/mct_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module mct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/multi_slot_countdown_timer.sv
// channel | dir | payload                                   | transaction when
// i_cmd   | in  | kind, slot_index, load_value, notify      | valid && ready
// o_rep   | out | expired_slot, last                        | valid && ready
//
// set, stop and ignored ticks finish in S_IDLE; set-if-idle adds S_CHECK (ram read)
// an enabled tick steps through S_RD and S_UPD for each slot in turn through
// the one count ram port, then S_EMIT sends each reported expiry in order
// i_cmd.ready is high only while idle; reports wait while o_rep.ready is low
// synchronous active-low reset clears the per-slot valid bits at once
// depends on mct_pkg, mct_ifs, mct_ram, assert_macros.svh
`include "assert_macros.svh"

module multi_slot_countdown_timer import mct_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mct_cmd_if.sink     i_cmd,
    mct_rep_if.source   o_rep
);

    localparam int AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W = COUNT_W + 1;

    t_state                r_state, n_state;
    logic                  r_tick_en, n_tick_en;
    logic [NUM_SLOTS-1:0]  r_vld, n_vld;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_addr, n_addr;
    logic [LOAD_W-1:0]     r_load, n_load;
    logic                  r_notify, n_notify;
    logic                  r_any, n_any;
    logic [REP_CNT_W-1:0]  r_nrep, n_nrep;
    logic [SLOT_W-1:0]     r_eidx, n_eidx;
    logic [SLOT_W-1:0]     r_rep [MAX_REPORTS];
    logic [SLOT_W-1:0]     n_rep [MAX_REPORTS];
    logic                  r_rd_vld;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WORD_W-1:0]     wdata;
    logic [AW-1:0]         raddr;
    logic [WORD_W-1:0]     rdata;

    logic [IDX_WIDE_W-1:0] cmd_wide;
    logic [IDX_WIDE_W-1:0] scan_wide;
    logic [AW-1:0]         cmd_addr;
    logic                  in_range;
    logic [COUNT_W-1:0]    cur_count;
    logic                  cur_notify;
    logic                  cmd_acc;
    logic                  rep_acc;
    logic                  rep_last;

    mct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cmd_wide   = IDX_WIDE_W'(i_cmd.slot_index);
    assign scan_wide  = IDX_WIDE_W'(r_idx);
    assign cmd_addr   = cmd_wide[AW-1:0];
    assign in_range   = cmd_wide < IDX_WIDE_W'(NUM_SLOTS);
    assign cur_count  = r_rd_vld ? rdata[COUNT_W-1:0] : '0;
    assign cur_notify = r_rd_vld & rdata[COUNT_W];

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rep.valid        = (r_state == S_EMIT);
    assign o_rep.expired_slot = r_rep[r_eidx];
    assign rep_last           = (REP_CNT_W'(r_eidx) + REP_CNT_W'(1)) == r_nrep;
    assign o_rep.last         = rep_last;
    assign cmd_acc            = i_cmd.valid & i_cmd.ready;
    assign rep_acc            = o_rep.valid & o_rep.ready;

    always_comb begin
        n_state   = r_state;
        n_tick_en = r_tick_en;
        n_vld     = r_vld;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_load    = r_load;
        n_notify  = r_notify;
        n_any     = r_any;
        n_nrep    = r_nrep;
        n_eidx    = r_eidx;
        n_rep     = r_rep;
        we        = 1'b0;
        waddr     = r_addr;
        wdata     = {r_notify, sat_load(r_load)};
        raddr     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                raddr = cmd_addr;
                if (cmd_acc) begin
                    case (t_kind'(i_cmd.kind))
                        KIND_TICK: begin
                            if (r_tick_en) begin
                                n_idx   = '0;
                                n_any   = 1'b0;
                                n_nrep  = '0;
                                n_state = S_RD;
                            end
                        end
                        KIND_SET: begin
                            if (in_range) begin
                                we              = 1'b1;
                                waddr           = cmd_addr;
                                wdata           = {i_cmd.notify, sat_load(i_cmd.load_value)};
                                n_vld[cmd_addr] = 1'b1;
                                n_tick_en       = 1'b1;
                            end
                        end
                        KIND_SET_IDLE: begin
                            if (in_range) begin
                                n_addr   = cmd_addr;
                                n_load   = i_cmd.load_value;
                                n_notify = i_cmd.notify;
                                n_state  = S_CHECK;
                            end
                        end
                        KIND_STOP: begin
                            if (in_range) begin
                                n_vld[cmd_addr] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (cur_count == '0) begin
                    we            = 1'b1;
                    n_vld[r_addr] = 1'b1;
                    n_tick_en     = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (cur_count > COUNT_W'(1)) begin
                    we    = 1'b1;
                    waddr = r_idx;
                    wdata = {cur_notify, cur_count - COUNT_W'(1)};
                    n_any = 1'b1;
                end else if (cur_count == COUNT_W'(1)) begin
                    n_vld[r_idx] = 1'b0;
                    if (cur_notify && r_nrep < REP_CNT_W'(MAX_REPORTS)) begin
                        n_rep[r_nrep[SLOT_W-1:0]] = scan_wide[SLOT_W-1:0];
                        n_nrep                    = r_nrep + REP_CNT_W'(1);
                    end
                end
                if (r_idx == AW'(NUM_SLOTS - 1)) begin
                    n_tick_en = n_any;
                    n_eidx    = '0;
                    n_state   = (n_nrep != '0) ? S_EMIT : S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                if (rep_acc) begin
                    if (rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_eidx = r_eidx + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick_en <= 1'b0;
            r_vld     <= '0;
            r_nrep    <= '0;
            r_eidx    <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick_en <= n_tick_en;
            r_vld     <= n_vld;
            r_nrep    <= n_nrep;
            r_eidx    <= n_eidx;
            r_rd_vld  <= r_vld[raddr];
        end
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_load   <= n_load;
        r_notify <= n_notify;
        r_any    <= n_any;
        r_rep    <= n_rep;
    end

    `MCT_ASSERT(a_rep_count, o_rep.valid |-> (r_nrep != '0 && r_nrep <= REP_CNT_W'(MAX_REPORTS)), "report sent with bad report count")
    `MCT_ASSERT(a_last_ends, (o_rep.valid && o_rep.ready && o_rep.last) |=> (r_state == S_IDLE), "last report did not end the tick")
    `MCT_ASSERT(a_tick_off, $fell(r_tick_en) |-> ($past(r_state == S_UPD) || $past(!i_rst_n)), "ticking disabled outside a scan")
    `MCT_ASSERT(a_busy_scan, (r_state == S_RD || r_state == S_UPD) |-> (r_tick_en && !i_cmd.ready), "scan without ticking enabled")

endmodule
